@@ hw/rtl/day_cycle_keyframe_selector_core_macros.svh @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector assertion macros
// Shared assertion forms for the checker of the selector core.
// ---------------------------------------------------------------------------
`ifndef DAY_CYCLE_KEYFRAME_SELECTOR_CORE_MACROS_SVH
`define DAY_CYCLE_KEYFRAME_SELECTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCKF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DCKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/dckf_pkg.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector package
// Widths, constants, codes and helper functions shared by the selector.
// ---------------------------------------------------------------------------
package dckf_pkg;

   localparam int MAX_KEYS = 16;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int TIME_W   = 21;
   localparam int FRAC_W   = 16;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int STEP_W   = $clog2(FRAC_W);

   localparam logic [TIME_W-1:0]   DAY_TICKS  = TIME_W'(1382400);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
   localparam logic [CNT_W-1:0]    KEYS_MAX   = CNT_W'(MAX_KEYS);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_INVAL = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SCAN    = 9'b000000010,
      ST_FETCH_P = 9'b000000100,
      ST_FETCH_N = 9'b000001000,
      ST_CHECK   = 9'b000010000,
      ST_SETUP   = 9'b000100000,
      ST_PREP    = 9'b001000000,
      ST_DIV     = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
   } div_stat_type;

   function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W-1:0] t);
      return (t > DAY_TICKS) ? DAY_TICKS : t;
   endfunction

   // Distance going forward around the day from a to b.
   function automatic logic [TIME_W-1:0] circ_diff(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      if (a > b) begin
         s = {1'b0, DAY_TICKS} - {1'b0, a} + {1'b0, b};
      end else begin
         s = {1'b0, b} - {1'b0, a};
      end
      return s[TIME_W-1:0];
   endfunction

endpackage

@@ hw/rtl/dckf_if.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector channels
// Valid/ready interfaces for the request and the response channel.
// ---------------------------------------------------------------------------
interface dckf_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     command;
   logic [dckf_pkg::IDX_W-1:0]     key_index;
   logic [dckf_pkg::TIME_W-1:0]    time_value;

   modport source (output valid, output command, output key_index, output time_value,
                   input ready);
   modport sink (input valid, input command, input key_index, input time_value,
                 output ready);
endinterface

interface dckf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dckf_pkg::IDX_W-1:0]     prev_index;
   logic [dckf_pkg::IDX_W-1:0]     next_index;
   logic [dckf_pkg::WEIGHT_W-1:0]  blend_weight;

   modport source (output valid, output prev_index, output next_index,
                   output blend_weight, input ready);
   modport sink (input valid, input prev_index, input next_index, input blend_weight,
                 output ready);
endinterface

@@ hw/rtl/dckf_ram.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector RAM
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module dckf_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dckf_div.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector divider
// Restoring divider that produces the fractional bits of a proper fraction,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dckf_div (
   input  logic                   clock,
   input  logic                   reset,
   input  dckf_pkg::div_cmd_type  cmd,
   output dckf_pkg::div_stat_type stat
);

   logic                            busy_ff, busy_in;
   logic [dckf_pkg::STEP_W-1:0]     count_ff, count_in;
   logic [dckf_pkg::TIME_W-1:0]     rem_ff, rem_in;
   logic [dckf_pkg::TIME_W-1:0]     len_ff, len_in;
   logic [dckf_pkg::FRAC_W-1:0]     quot_ff, quot_in;
   logic                            done_ff, done_in;
   logic [dckf_pkg::TIME_W:0]       rem_dbl;
   logic                            fits;

   assign rem_dbl = {rem_ff, 1'b0};
   assign fits    = rem_dbl >= {1'b0, len_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = dckf_pkg::STEP_W'(dckf_pkg::FRAC_W - 1);
         rem_in   = cmd.dividend;
         len_in   = cmd.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? dckf_pkg::TIME_W'(rem_dbl - {1'b0, len_ff})
                        : rem_dbl[dckf_pkg::TIME_W-1:0];
         quot_in = {quot_ff[dckf_pkg::FRAC_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      len_ff   <= len_in;
      quot_ff  <= quot_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quot_ff;

endmodule

@@ hw/rtl/day_cycle_keyframe_selector_core.sv @@
// Load, invalidate and unknown transactions are handled in ST_IDLE and give no response.
// A tick with a held pair that does not advance goes through FETCH_P, FETCH_N, CHECK,
// SETUP and PREP to DONE, and through DIV as well when the weight needs the divider.
// A first search or an advance adds a scan in SCAN of the keys in use, one at a time
// through the one RAM read port. No transaction is taken until the response
// is in its register, where it may wait. Synchronous reset clears the held pair.
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector core
// Keyframe table in RAM, bracketing-pair search and blend-weight computation.
// Synchronous reset also clears the response valid bit and sets key_count to one.
// ---------------------------------------------------------------------------
module day_cycle_keyframe_selector_core (
   input  logic                         clock,
   input  logic                         reset,
   dckf_req_if.sink                     req_chan,
   dckf_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [dckf_pkg::CNT_W-1:0]   csr_wr_data
);

   localparam int TW = dckf_pkg::TIME_W;
   localparam int IW = dckf_pkg::IDX_W;
   localparam int CW = dckf_pkg::CNT_W;
   localparam int WW = dckf_pkg::WEIGHT_W;

   dckf_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          key_count_ff, key_count_in;
   logic [TW-1:0]          t_ff, t_in;
   logic [IW-1:0]          prev_ff, prev_in;
   logic [IW-1:0]          next_ff, next_in;
   logic                   pair_valid_ff, pair_valid_in;
   logic                   final_ff, final_in;
   logic [TW-1:0]          tp_ff, tp_in;
   logic [TW-1:0]          tn_ff, tn_in;
   logic [CW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [TW-1:0]          len_ff, len_in;
   logic [TW-1:0]          dist_ff, dist_in;
   logic                   inside_ff, inside_in;
   logic [WW-1:0]          weight_ff, weight_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]          rsp_prev_ff, rsp_prev_in;
   logic [IW-1:0]          rsp_next_ff, rsp_next_in;
   logic [WW-1:0]          rsp_weight_ff, rsp_weight_in;

   logic                   ram_wr_en;
   logic [IW-1:0]          ram_wr_addr;
   logic [TW-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [IW-1:0]          ram_rd_addr;
   logic [TW-1:0]          ram_rd_data;

   dckf_pkg::div_cmd_type  div_cmd;
   dckf_pkg::div_stat_type div_stat;

   logic [CW-1:0]          keys_used;
   logic [IW-1:0]          last_idx;
   logic                   req_fire;
   logic [TW-1:0]          req_time;
   logic                   scan_hit;
   logic                   scan_all;
   logic                   advance;

   dckf_ram #(
      .DEPTH (dckf_pkg::MAX_KEYS),
      .WIDTH (TW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dckf_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   always_comb begin
      if (key_count_ff == '0) begin
         keys_used = CW'(1);
      end else if (key_count_ff > dckf_pkg::KEYS_MAX) begin
         keys_used = dckf_pkg::KEYS_MAX;
      end else begin
         keys_used = key_count_ff;
      end
   end

   assign last_idx = IW'(keys_used - 1'b1);
   assign req_fire = req_chan.valid && (state_ff == dckf_pkg::ST_IDLE);
   assign req_time = dckf_pkg::clamp_time(req_chan.time_value);
   assign scan_hit = cmp_vld_ff && (ram_rd_data >= t_ff);
   assign scan_all = scan_addr_ff == keys_used;

   always_comb begin
      if (tp_ff > ram_rd_data) begin
         advance = (t_ff > ram_rd_data) && (t_ff < tp_ff);
      end else begin
         advance = t_ff > ram_rd_data;
      end
   end

   assign ram_wr_en   = req_fire && (req_chan.command == dckf_pkg::CMD_LOAD);
   assign ram_wr_addr = req_chan.key_index;
   assign ram_wr_data = req_time;

   always_comb begin
      state_in      = state_ff;
      key_count_in  = csr_wr_en ? csr_wr_data : key_count_ff;
      t_in          = t_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      pair_valid_in = pair_valid_ff;
      final_in      = final_ff;
      tp_in         = tp_ff;
      tn_in         = tn_ff;
      scan_addr_in  = scan_addr_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      len_in        = len_ff;
      dist_in       = dist_ff;
      inside_in     = inside_ff;
      weight_in     = weight_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_prev_in   = rsp_prev_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_weight_in = rsp_weight_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_addr_ff[IW-1:0];
      div_cmd       = '{start: 1'b0, dividend: dist_ff, divisor: len_ff};

      unique case (state_ff)
         dckf_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.command)
                  dckf_pkg::CMD_INVAL: begin
                     pair_valid_in = 1'b0;
                     prev_in       = '0;
                     next_in       = '0;
                  end
                  dckf_pkg::CMD_TICK: begin
                     t_in         = req_time;
                     final_in     = 1'b0;
                     scan_addr_in = '0;
                     cmp_vld_in   = 1'b0;
                     state_in     = pair_valid_ff ? dckf_pkg::ST_FETCH_P
                                                  : dckf_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         dckf_pkg::ST_SCAN: begin
            if (scan_hit || scan_all) begin
               final_in = 1'b1;
               state_in = dckf_pkg::ST_FETCH_P;
               if (!pair_valid_ff) begin
                  pair_valid_in = 1'b1;
                  if (scan_hit) begin
                     next_in = cmp_idx_ff;
                     prev_in = (cmp_idx_ff == '0) ? last_idx : cmp_idx_ff - 1'b1;
                  end else begin
                     next_in = '0;
                     prev_in = last_idx;
                  end
               end else begin
                  prev_in = next_ff;
                  next_in = scan_hit ? cmp_idx_ff : '0;
               end
            end else begin
               ram_rd_en    = 1'b1;
               cmp_vld_in   = 1'b1;
               cmp_idx_in   = scan_addr_ff[IW-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         dckf_pkg::ST_FETCH_P: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = prev_ff;
            state_in    = dckf_pkg::ST_FETCH_N;
         end
         dckf_pkg::ST_FETCH_N: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_ff;
            tp_in       = ram_rd_data;
            state_in    = dckf_pkg::ST_CHECK;
         end
         dckf_pkg::ST_CHECK: begin
            tn_in = ram_rd_data;
            if (!final_ff && advance) begin
               scan_addr_in = '0;
               cmp_vld_in   = 1'b0;
               state_in     = dckf_pkg::ST_SCAN;
            end else begin
               state_in = dckf_pkg::ST_SETUP;
            end
         end
         dckf_pkg::ST_SETUP: begin
            len_in  = dckf_pkg::circ_diff(tp_ff, tn_ff);
            dist_in = dckf_pkg::circ_diff(tp_ff, t_ff);
            if (tp_ff > tn_ff) begin
               inside_in = (t_ff >= tp_ff) || (t_ff <= tn_ff);
            end else begin
               inside_in = (t_ff >= tp_ff) && (t_ff <= tn_ff);
            end
            state_in = dckf_pkg::ST_PREP;
         end
         dckf_pkg::ST_PREP: begin
            if ((len_ff == '0) || !inside_ff) begin
               weight_in = '0;
               state_in  = dckf_pkg::ST_DONE;
            end else if (dist_ff >= len_ff) begin
               weight_in = dckf_pkg::WEIGHT_ONE;
               state_in  = dckf_pkg::ST_DONE;
            end else begin
               div_cmd.start = 1'b1;
               state_in      = dckf_pkg::ST_DIV;
            end
         end
         dckf_pkg::ST_DIV: begin
            if (div_stat.done) begin
               weight_in = {1'b0, div_stat.quotient};
               state_in  = dckf_pkg::ST_DONE;
            end
         end
         dckf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_prev_in   = prev_ff;
               rsp_next_in   = next_ff;
               rsp_weight_in = weight_ff;
               state_in      = dckf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dckf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dckf_pkg::ST_IDLE;
         key_count_ff  <= CW'(1);
         prev_ff       <= '0;
         next_ff       <= '0;
         pair_valid_ff <= 1'b0;
         final_ff      <= 1'b0;
         scan_addr_ff  <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         prev_ff       <= prev_in;
         next_ff       <= next_in;
         pair_valid_ff <= pair_valid_in;
         final_ff      <= final_in;
         scan_addr_ff  <= scan_addr_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      tp_ff         <= tp_in;
      tn_ff         <= tn_in;
      cmp_idx_ff    <= cmp_idx_in;
      len_ff        <= len_in;
      dist_ff       <= dist_in;
      inside_ff     <= inside_in;
      weight_ff     <= weight_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   assign req_chan.ready        = state_ff == dckf_pkg::ST_IDLE;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.prev_index   = rsp_prev_ff;
   assign rsp_chan.next_index   = rsp_next_ff;
   assign rsp_chan.blend_weight = rsp_weight_ff;

endmodule

@@ hw/rtl/dckf_checker.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector checker
// Port-level assertions on the selector core, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "day_cycle_keyframe_selector_core_macros.svh"

module dckf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dckf_pkg::IDX_W-1:0]    rsp_prev_index,
   input logic [dckf_pkg::IDX_W-1:0]    rsp_next_index,
   input logic [dckf_pkg::WEIGHT_W-1:0] rsp_blend_weight
);

   logic req_tick;
   logic req_other;

   assign req_tick  = req_valid && req_ready && (req_command == dckf_pkg::CMD_TICK);
   assign req_other = req_valid && req_ready && (req_command != dckf_pkg::CMD_TICK);

   `DCKF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_blend_weight))
   `DCKF_ASSERT_NEXT(a_tick_busy, clock, reset, req_tick, !req_ready)
   `DCKF_ASSERT_NEXT(a_other_quick, clock, reset, req_other, req_ready)
   `DCKF_ASSERT_SAME(a_weight_range, clock, reset, rsp_valid, rsp_blend_weight <= dckf_pkg::WEIGHT_ONE)
   `DCKF_ASSERT_SAME(a_weight_pair, clock, reset, rsp_valid && (rsp_blend_weight != '0), rsp_prev_index != rsp_next_index)

endmodule

bind day_cycle_keyframe_selector_core dckf_checker u_dckf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_command      (req_chan.command),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_prev_index   (rsp_chan.prev_index),
   .rsp_next_index   (rsp_chan.next_index),
   .rsp_blend_weight (rsp_chan.blend_weight)
);

@@ dv/tb_day_cycle_keyframe_selector_core.sv @@
// ---------------------------------------------------------------------------
// Day-cycle keyframe selector testbench
// Loads keyframe tables, sets the key count while the core is idle, and sends
// directed and random ticks, invalidates, loads and unknown commands under random
// back-pressure. A predictor tracks the table and the held pair, and every
// response is compared with the oldest predicted bracket.
// ---------------------------------------------------------------------------
module tb_day_cycle_keyframe_selector_core;

   localparam int TW   = dckf_pkg::TIME_W;
   localparam int IW   = dckf_pkg::IDX_W;
   localparam int CW   = dckf_pkg::CNT_W;
   localparam int WW   = dckf_pkg::WEIGHT_W;
   localparam int KEYS = dckf_pkg::MAX_KEYS;

   typedef logic [TW-1:0] tod_type;

   typedef struct packed {
      logic [1:0]    command;
      logic [IW-1:0] key_index;
      tod_type       time_value;
   } frame_request_type;

   typedef struct packed {
      logic [IW-1:0] prev_idx;
      logic [IW-1:0] next_idx;
      logic [WW-1:0] weight;
   } bracket_type;

   localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
   localparam int unsigned DAY           = dckf_pkg::DAY_TICKS;
   localparam int unsigned TIME_TOP      = (1 << TW) - 1;
   localparam int unsigned ITEM_TARGET   = 1750;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CW-1:0] csr_wr_data;

   dckf_req_if req_if();
   dckf_rsp_if rsp_if();

   day_cycle_keyframe_selector_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predictor state.
   tod_type       key_time [KEYS] = '{default: '0};
   logic [IW-1:0] held_prev       = '0;
   logic [IW-1:0] held_next       = '0;
   logic          pair_held       = 1'b0;
   logic [CW-1:0] count_setting   = CW'(1);

   frame_request_type pending_requests [$];
   bracket_type       expected_brackets [$];
   frame_request_type presented;

   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned req_idle_pct   = 29;
   int unsigned rsp_stall_pct  = 29;
   int unsigned hold_left      = 0;
   logic        hold_request   = 1'b0;
   logic        hold_started   = 1'b0;

   function automatic int unsigned keys_active();
      if (count_setting == '0) return 1;
      if (count_setting > CW'(KEYS)) return KEYS;
      return int'(count_setting);
   endfunction

   function automatic int unsigned first_key_at_or_after(int unsigned n, tod_type t);
      for (int unsigned i = 0; i < n; i++) begin
         if (key_time[i] >= t) return i;
      end
      return n;
   endfunction

   function automatic longint unsigned fwd_gap(tod_type a, tod_type b);
      if (a > b) return longint'(DAY) - longint'(a) + longint'(b);
      return longint'(b) - longint'(a);
   endfunction

   function automatic logic [WW-1:0] blend_at(tod_type t, tod_type lo, tod_type hi);
      longint unsigned span_len;
      longint unsigned w;
      logic in_span;
      span_len = fwd_gap(lo, hi);
      if (span_len == 0) return '0;
      in_span = (lo > hi) ? (t >= lo || t <= hi) : (t >= lo && t <= hi);
      if (!in_span) return '0;
      w = fwd_gap(lo, t) * 65536 / span_len;
      if (w > 65536) w = 65536;
      return WW'(w);
   endfunction

   function automatic bracket_type predict_tick(tod_type t);
      int unsigned n;
      int unsigned hit;
      tod_type tp;
      tod_type tn;
      logic moves_on;
      bracket_type res;
      n = keys_active();
      if (!pair_held) begin
         hit = first_key_at_or_after(n, t);
         if (hit >= n) begin
            held_prev = IW'(n - 1);
            held_next = '0;
         end else begin
            held_next = IW'(hit);
            held_prev = (hit == 0) ? IW'(n - 1) : IW'(hit - 1);
         end
         pair_held = 1'b1;
      end else begin
         tp = key_time[held_prev];
         tn = key_time[held_next];
         moves_on = (tp > tn) ? (t > tn && t < tp) : (t > tn);
         if (moves_on) begin
            hit = first_key_at_or_after(n, t);
            held_prev = held_next;
            held_next = (hit >= n) ? '0 : IW'(hit);
         end
      end
      res.prev_idx = held_prev;
      res.next_idx = held_next;
      res.weight   = blend_at(t, key_time[held_prev], key_time[held_next]);
      return res;
   endfunction

   function automatic void apply_request(frame_request_type item);
      tod_type t;
      t = (item.time_value > dckf_pkg::DAY_TICKS) ? dckf_pkg::DAY_TICKS : item.time_value;
      case (item.command)
         dckf_pkg::CMD_LOAD: begin
            key_time[item.key_index] = t;
         end
         dckf_pkg::CMD_INVAL: begin
            pair_held = 1'b0;
            held_prev = '0;
            held_next = '0;
         end
         dckf_pkg::CMD_TICK: begin
            expected_brackets.push_back(predict_tick(t));
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.command    <= dckf_pkg::CMD_LOAD;
         req_if.key_index  <= '0;
         req_if.time_value <= '0;
      end else begin
         if (req_if.valid && req_if.ready) apply_request(presented);
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               presented = pending_requests.pop_front();
               req_if.valid      <= 1'b1;
               req_if.command    <= presented.command;
               req_if.key_index  <= presented.key_index;
               req_if.time_value <= presented.time_value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      bracket_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_brackets.size() == 0) begin
               report_mismatch("response with no tick outstanding");
            end else begin
               want = expected_brackets.pop_front();
               if (rsp_if.prev_index !== want.prev_idx)
                  report_mismatch($sformatf("prev_index got %0d expected %0d",
                                            rsp_if.prev_index, want.prev_idx));
               if (rsp_if.next_index !== want.next_idx)
                  report_mismatch($sformatf("next_index got %0d expected %0d",
                                            rsp_if.next_index, want.next_idx));
               if (rsp_if.blend_weight !== want.weight)
                  report_mismatch($sformatf("blend_weight got %0d expected %0d",
                                            rsp_if.blend_weight, want.weight));
            end
         end
         if (hold_request && !hold_started) begin
            hold_left    = HOLD_CYCLES;
            hold_started = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("tb_day_cycle_keyframe_selector_core failed");
         $finish;
      end
   end

   task automatic push_request(logic [1:0] cmd, logic [IW-1:0] idx, tod_type t);
      frame_request_type item;
      item.command    = cmd;
      item.key_index  = idx;
      item.time_value = t;
      pending_requests.push_back(item);
      items_sent++;
   endtask

   task automatic push_tick(int unsigned t);
      push_request(dckf_pkg::CMD_TICK, IW'($urandom_range(0, KEYS - 1)), TW'(t));
   endtask

   task automatic push_invalidate();
      push_request(dckf_pkg::CMD_INVAL, IW'($urandom_range(0, KEYS - 1)),
                   TW'($urandom_range(0, TIME_TOP)));
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_brackets.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key_count(logic [CW-1:0] v);
      wait_quiet();
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= v;
      count_setting = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int unsigned round_keys [KEYS];
      int unsigned round_no;
      int unsigned n_used;
      int unsigned r;
      int unsigned base;
      int unsigned sweep;
      int unsigned v;
      int unsigned idx;
      logic        unsorted;
      logic [CW-1:0] setting;

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Evenly spaced table; the last load saturates to the day end.
      for (int i = 0; i < KEYS; i++) begin
         push_request(dckf_pkg::CMD_LOAD, IW'(i), (i == KEYS - 1) ? TW'(TIME_TOP)
                                                                  : TW'(i * 86400));
      end
      push_tick(0);
      push_request(CMD_UNKNOWN, '1, '1);
      write_key_count(CW'(16));
      push_invalidate();
      push_tick(TIME_TOP);
      push_tick(100);
      push_invalidate();
      push_tick(43200);
      push_tick(86401);
      write_key_count(CW'(0));
      push_invalidate();
      push_tick(5000);
      write_key_count(CW'(31));
      push_invalidate();
      push_tick(1300000);
      write_key_count(CW'(5));
      push_tick(1382399);
      push_request(dckf_pkg::CMD_LOAD, IW'(3), TW'(10));
      push_invalidate();
      push_tick(50);
      push_tick(300000);
      push_tick(DAY);

      round_no = 0;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 10) setting = CW'(0);
         else if (r < 20) setting = CW'(31);
         else if (r < 30) setting = CW'(16);
         else if (r < 35) setting = CW'(1);
         else setting = CW'($urandom_range(2, 16));
         write_key_count(setting);
         n_used = (setting == 0) ? 1 : ((setting > KEYS) ? KEYS : setting);

         if (round_no == 2) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct  = 29;
            rsp_stall_pct = 29;
         end

         unsorted = ($urandom_range(9) == 0);
         base     = $urandom_range(0, DAY / 32);
         for (int i = 0; i < KEYS; i++) begin
            if (unsorted || i >= n_used) begin
               round_keys[i] = $urandom_range(0, DAY);
               v = round_keys[i];
            end else begin
               round_keys[i] = base;
               v = base;
               if (i == n_used - 1 && $urandom_range(19) == 0) begin
                  round_keys[i] = DAY;
                  v = $urandom_range(DAY, TIME_TOP);
               end
               if ($urandom_range(7) != 0) base += $urandom_range(1, DAY / (n_used + 1));
            end
            push_request(dckf_pkg::CMD_LOAD, IW'(i), TW'(v));
         end
         if ($urandom_range(4) != 0) push_invalidate();

         if (round_no == 4) hold_request = 1'b1;

         sweep = $urandom_range(0, DAY);
         repeat ($urandom_range(40, 80)) begin
            r = $urandom_range(99);
            if (r < 55) begin
               sweep += $urandom_range(0, DAY / (2 * n_used));
               if (sweep > DAY) sweep -= DAY;
               push_tick(sweep);
            end else if (r < 70) begin
               sweep = round_keys[$urandom_range(0, n_used - 1)] + $urandom_range(0, 1);
               if (sweep > DAY) sweep = DAY;
               push_tick(sweep);
            end else if (r < 78) begin
               push_tick(sweep);
            end else if (r < 86) begin
               sweep = $urandom_range(0, DAY);
               push_tick(sweep);
            end else if (r < 90) begin
               push_tick($urandom_range(DAY + 1, TIME_TOP));
            end else if (r < 94) begin
               push_invalidate();
            end else if (r < 97) begin
               idx = $urandom_range(0, KEYS - 1);
               v   = $urandom_range(0, TIME_TOP);
               round_keys[idx] = (v > DAY) ? DAY : v;
               push_request(dckf_pkg::CMD_LOAD, IW'(idx), TW'(v));
            end else begin
               push_request(CMD_UNKNOWN, IW'($urandom_range(0, KEYS - 1)),
                            TW'($urandom_range(0, TIME_TOP)));
            end
         end
         round_no++;
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("tb_day_cycle_keyframe_selector_core passed");
      end else begin
         $display("tb_day_cycle_keyframe_selector_core failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dckf_pkg.sv
hw/rtl/dckf_if.sv
hw/rtl/dckf_ram.sv
hw/rtl/dckf_div.sv
hw/rtl/day_cycle_keyframe_selector_core.sv
hw/rtl/dckf_checker.sv
dv/tb_day_cycle_keyframe_selector_core.sv
